// ===== src/tangent_plane_basis_from_angles_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tangent plane basis block
// Shared concurrent check forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TANGENT_PLANE_BASIS_FROM_ANGLES_DEFINES_SVH
`define TANGENT_PLANE_BASIS_FROM_ANGLES_DEFINES_SVH

// a must hold in the same cycle whenever cond holds
`define TPB_ASSERT_IMPLIES(label, clk, rst, cond, a) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (a)) \
      else $error("tpb check failed");

// a must hold in every cycle out of reset
`define TPB_ASSERT_ALWAYS(label, clk, rst, a) \
   label: assert property (@(posedge clk) disable iff (rst) (a)) \
      else $error("tpb check failed");

`endif

// ===== src/tpb_pkg.sv =====
// ----------------------------------------------------------------------------
// tpb_pkg
// Constants, CORDIC angle table and shared types of the tangent plane block.
// ----------------------------------------------------------------------------
package tpb_pkg;

   localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;
   localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
   localparam logic signed [31:0] CORDIC_K    = 32'sd652032874;

   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } tpb_quad_type;

   typedef struct packed {
      logic neg_xy;
      logic neg_xz;
      logic neg_z;
      logic degenerate;
   } tpb_flags_type;

endpackage

// ===== src/tpb_div_pipe.sv =====
// ----------------------------------------------------------------------------
// tpb_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// The dividend is {in_rem, in_low} with in_rem below in_den.
// ----------------------------------------------------------------------------
module tpb_div_pipe #(
   parameter int DW = 32,
   parameter int QW = 33,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [QW-1:0] in_low,
   input  logic [DW-1:0] in_den,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [PW-1:0] out_pay
);

   logic          valid_ff [QW];
   logic [DW-1:0] r_ff     [QW];
   logic [QW-1:0] low_ff   [QW];
   logic [DW-1:0] den_ff   [QW];
   logic [PW-1:0] pay_ff   [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          valid_src;
      logic [DW-1:0] r_src;
      logic [QW-1:0] low_src;
      logic [DW-1:0] den_src;
      logic [PW-1:0] pay_src;
      logic [DW:0]   t;
      logic          ge;
      logic [DW-1:0] r_in;
      logic [QW-1:0] low_in;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign r_src     = in_rem;
         assign low_src   = in_low;
         assign den_src   = in_den;
         assign pay_src   = in_pay;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign r_src     = r_ff[k-1];
         assign low_src   = low_ff[k-1];
         assign den_src   = den_ff[k-1];
         assign pay_src   = pay_ff[k-1];
      end

      always_comb begin
         t      = {r_src, low_src[QW-1]};
         ge     = (t >= {1'b0, den_src});
         r_in   = ge ? DW'(t - {1'b0, den_src}) : DW'(t);
         low_in = {low_src[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]   <= r_in;
            low_ff[k] <= low_in;
            den_ff[k] <= den_src;
            pay_ff[k] <= pay_src;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = low_ff[QW-1];
   assign out_pay   = pay_ff[QW-1];

endmodule

// ===== src/tpb_isqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// tpb_isqrt_pipe
// Pipelined floor square root, one root bit per stage, with side payload.
// ----------------------------------------------------------------------------
module tpb_isqrt_pipe #(
   parameter int RW = 32,
   parameter int PW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_n,
   input  logic [PW-1:0]   in_pay,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [PW-1:0]   out_pay
);

   localparam int AW = RW + 3;

   logic            valid_ff [RW];
   logic [AW-1:0]   rem_ff   [RW];
   logic [RW-1:0]   root_ff  [RW];
   logic [2*RW-1:0] n_ff     [RW];
   logic [PW-1:0]   pay_ff   [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic            valid_src;
      logic [AW-1:0]   rem_src;
      logic [RW-1:0]   root_src;
      logic [2*RW-1:0] n_src;
      logic [PW-1:0]   pay_src;
      logic [AW-1:0]   cur;
      logic [AW-1:0]   trial;
      logic [AW-1:0]   rem_in;
      logic [RW-1:0]   root_in;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = '0;
         assign root_src  = '0;
         assign n_src     = in_n;
         assign pay_src   = in_pay;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign root_src  = root_ff[k-1];
         assign n_src     = n_ff[k-1];
         assign pay_src   = pay_ff[k-1];
      end

      always_comb begin
         cur   = {rem_src[AW-3:0], n_src[2*RW-1 -: 2]};
         trial = AW'({root_src, 2'b01});
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_src[RW-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_src[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            n_ff[k]    <= {n_src[2*RW-3:0], 2'b00};
            pay_ff[k]  <= pay_src;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_pay   = pay_ff[RW-1];

endmodule

// ===== src/tpb_sincos.sv =====
// ----------------------------------------------------------------------------
// tpb_sincos
// Pipelined sine and cosine of a fixed-point degree angle: wrap, quarter
// split, conversion to radians, CORDIC stages and quadrant mapping.
// ----------------------------------------------------------------------------
module tpb_sincos #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [15:0] in_angle,
   output logic               out_valid,
   output logic signed [31:0] out_cos,
   output logic signed [31:0] out_sin
);

   localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
   localparam int FULL    = 4 * QUARTER;
   localparam int OFFSET  = FULL * ((32768 + FULL - 1) / FULL);
   localparam int MW      = 29;
   localparam int ZDW     = $clog2(QUARTER + 1);
   localparam int WW      = ZDW + 2;
   localparam int ZQW     = 31;
   localparam int RB      = 2 * ZDW;
   localparam int KS      = 3 * ZDW;
   localparam int MB      = KS - ZDW + 1;
   localparam int PMW     = RB + MB;
   localparam int CS      = CORDIC_STEPS;
   // rem * HALF_PI / QUARTER = rem * ZA + rem * ZB / QUARTER
   localparam longint ZA  = longint'(tpb_pkg::HALF_PI_Q30) / QUARTER;
   localparam longint ZB  = longint'(tpb_pkg::HALF_PI_Q30) % QUARTER;
   // reciprocal of QUARTER, exact floor for products below 2**RB
   localparam longint ZM  = ((longint'(1) << KS) + QUARTER - 1) / QUARTER;

   // wrap into one turn
   logic [MW-1:0] wrap_m;
   logic          v1_ff;
   logic [WW-1:0] wrap_ff;

   always_comb begin
      wrap_m = MW'(OFFSET) + MW'(in_angle);
      for (int k = 7; k >= 0; k--) begin
         if (wrap_m >= (MW'(FULL) << k)) begin
            wrap_m = wrap_m - (MW'(FULL) << k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wrap_ff <= WW'(wrap_m);
      end
   end

   // quarter split and scaling to radians
   tpb_pkg::tpb_quad_type quad_in;
   logic [WW-1:0]         rem_w;
   logic                  v2_ff;
   logic [ZQW-1:0]        pa_ff;
   logic [RB-1:0]         pb_ff;
   tpb_pkg::tpb_quad_type quad_ff;
   logic                  zero_ff;

   always_comb begin
      if (wrap_ff >= WW'(3 * QUARTER)) begin
         quad_in = tpb_pkg::QUAD_3;
         rem_w   = wrap_ff - WW'(3 * QUARTER);
      end else if (wrap_ff >= WW'(2 * QUARTER)) begin
         quad_in = tpb_pkg::QUAD_2;
         rem_w   = wrap_ff - WW'(2 * QUARTER);
      end else if (wrap_ff >= WW'(QUARTER)) begin
         quad_in = tpb_pkg::QUAD_1;
         rem_w   = wrap_ff - WW'(QUARTER);
      end else begin
         quad_in = tpb_pkg::QUAD_0;
         rem_w   = wrap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff   <= ZQW'(rem_w[ZDW-1:0]) * ZQW'(ZA);
         pb_ff   <= RB'(rem_w[ZDW-1:0]) * RB'(ZB);
         quad_ff <= quad_in;
         zero_ff <= (rem_w == '0);
      end
   end

   // fractional part through the reciprocal
   logic           v3_ff;
   logic [ZQW-1:0] pa3_ff;
   logic [PMW-1:0] pm_ff;
   logic [2:0]     pay3_ff;
   logic           v4_ff;
   logic [ZQW-1:0] z4_ff;
   logic [2:0]     pay4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa3_ff  <= pa_ff;
         pm_ff   <= PMW'(pb_ff) * PMW'(ZM);
         pay3_ff <= {quad_ff, zero_ff};
         z4_ff   <= pa3_ff + ZQW'(pm_ff[PMW-1:KS]);
         pay4_ff <= pay3_ff;
      end
   end

   logic           zv;
   logic [ZQW-1:0] zq;
   logic [2:0]     zpay;

   assign zv   = v4_ff;
   assign zq   = z4_ff;
   assign zpay = pay4_ff;

   // CORDIC rotation
   logic               cv_ff [CS];
   logic signed [31:0] x_ff  [CS];
   logic signed [31:0] y_ff  [CS];
   logic signed [32:0] z_ff  [CS];
   logic [2:0]         cp_ff [CS];

   for (genvar i = 0; i < CS; i++) begin : g_cordic
      logic               v_src;
      logic signed [31:0] x_src;
      logic signed [31:0] y_src;
      logic signed [32:0] z_src;
      logic [2:0]         p_src;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] x_in;
      logic signed [31:0] y_in;
      logic signed [32:0] z_in;

      if (i == 0) begin : g_first
         assign v_src = zv;
         assign x_src = tpb_pkg::CORDIC_K;
         assign y_src = '0;
         assign z_src = $signed({2'b00, zq});
         assign p_src = zpay;
      end else begin : g_next
         assign v_src = cv_ff[i-1];
         assign x_src = x_ff[i-1];
         assign y_src = y_ff[i-1];
         assign z_src = z_ff[i-1];
         assign p_src = cp_ff[i-1];
      end

      always_comb begin
         dx = y_src >>> i;
         dy = x_src >>> i;
         if (z_src >= 0) begin
            x_in = x_src - dx;
            y_in = y_src + dy;
            z_in = z_src - $signed(33'(tpb_pkg::ATAN_Q30[i]));
         end else begin
            x_in = x_src + dx;
            y_in = y_src - dy;
            z_in = z_src + $signed(33'(tpb_pkg::ATAN_Q30[i]));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i] <= 1'b0;
         end else if (en) begin
            cv_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]  <= x_in;
            y_ff[i]  <= y_in;
            z_ff[i]  <= z_in;
            cp_ff[i] <= p_src;
         end
      end
   end

   // quadrant mapping
   logic               zero_c;
   logic [1:0]         quad_c;
   logic signed [31:0] c0;
   logic signed [31:0] s0;
   logic signed [31:0] cos_in;
   logic signed [31:0] sin_in;
   logic               ov_ff;
   logic signed [31:0] cos_ff;
   logic signed [31:0] sin_ff;

   always_comb begin
      quad_c = cp_ff[CS-1][2:1];
      zero_c = cp_ff[CS-1][0];
      c0     = zero_c ? tpb_pkg::Q30_ONE : x_ff[CS-1];
      s0     = zero_c ? 32'sd0 : y_ff[CS-1];
      case (quad_c)
         tpb_pkg::QUAD_1: begin
            cos_in = -s0;
            sin_in = c0;
         end
         tpb_pkg::QUAD_2: begin
            cos_in = -c0;
            sin_in = -s0;
         end
         tpb_pkg::QUAD_3: begin
            cos_in = s0;
            sin_in = -c0;
         end
         default: begin
            cos_in = c0;
            sin_in = s0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= cv_ff[CS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;

endmodule

// ===== src/tangent_plane_basis_from_angles.sv =====
// ----------------------------------------------------------------------------
// tangent_plane_basis_from_angles
// Orthonormal tangent plane basis for the normal given by a tilt and a
// rotation angle, in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  direction  words carried
//  req_     in         tilt_angle, rotation_angle
//  rsp_     out        first_x..z, second_x..z, degenerate flag
//
//  One word enters per cycle while the output is not stalled; the pipeline
//  depth is set by the CORDIC stages, the square root and the quotient
//  dividers, each one bit or one rotation per stage.
//  Synchronous active-high reset clears all valid bits.
//  A stalled output word freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
`include "tangent_plane_basis_from_angles_defines.svh"

module tangent_plane_basis_from_angles #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int OUT_FRAC_BITS   = 15,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // tilt_angle, rotation_angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // first_x/y/z, second_x/y/z
   output logic        rsp_tuser   // degenerate
);

   localparam int FW  = $bits(tpb_pkg::tpb_flags_type);
   localparam int IPW = FW + 4 * 64;
   localparam int SH  = 30 - OUT_FRAC_BITS;
   localparam logic signed [34:0] RND = (SH > 0) ? (35'sd1 <<< (SH - 1)) : 35'sd0;

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   function automatic logic [15:0] to_out(input logic signed [34:0] v);
      logic signed [34:0] r;
      r = (v + RND) >>> SH;
      if (r > 35'sd32767) begin
         return 16'h7FFF;
      end else if (r < -35'sd32768) begin
         return 16'h8000;
      end
      return r[15:0];
   endfunction

   // sine and cosine of both angles
   logic               tv;
   logic               rv;
   logic signed [31:0] ct;
   logic signed [31:0] st;
   logic signed [31:0] cr;
   logic signed [31:0] sr;

   tpb_sincos #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STEPS    (CORDIC_STEPS)
   ) u_tilt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_angle  ($signed(req_tdata[15:0])),
      .out_valid (tv),
      .out_cos   (ct),
      .out_sin   (st)
   );

   tpb_sincos #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STEPS    (CORDIC_STEPS)
   ) u_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_angle  ($signed(req_tdata[31:16])),
      .out_valid (rv),
      .out_cos   (cr),
      .out_sin   (sr)
   );

   // normal vector
   logic               va_ff;
   logic signed [63:0] p_sx_ff;
   logic signed [63:0] p_cz_ff;
   logic signed [31:0] ny_a_ff;
   logic               vb_ff;
   logic signed [31:0] nx_b_ff;
   logic signed [31:0] ny_b_ff;
   logic signed [31:0] nz_b_ff;
   logic signed [63:0] nx_r;
   logic signed [63:0] nz_r;

   assign nx_r = (p_sx_ff + 64'sd536870912) >>> 30;
   assign nz_r = (p_cz_ff + 64'sd536870912) >>> 30;

   // products
   logic               vc_ff;
   logic signed [63:0] sq_y_ff;
   logic signed [63:0] sq_z_ff;
   logic signed [63:0] p_xy_ff;
   logic signed [63:0] p_xz_ff;
   logic [31:0]        mag_y_ff;
   logic [31:0]        mag_z_ff;
   logic               deg_c_ff;
   logic               neg_z_c_ff;

   // square root input
   tpb_pkg::tpb_flags_type flags_d;
   logic               vd_ff;
   logic [63:0]        n_ff;
   logic [IPW-1:0]     ipay_ff;

   always_comb begin
      flags_d.neg_xy     = (p_xy_ff > 0);
      flags_d.neg_xz     = (p_xz_ff > 0);
      flags_d.neg_z      = neg_z_c_ff;
      flags_d.degenerate = deg_c_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (en) begin
         va_ff <= tv;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_sx_ff    <= 64'(sr) * 64'(st);
         p_cz_ff    <= 64'(cr) * 64'(st);
         ny_a_ff    <= ct;
         nx_b_ff    <= nx_r[31:0];
         nz_b_ff    <= -nz_r[31:0];
         ny_b_ff    <= ny_a_ff;
         sq_y_ff    <= 64'(ny_b_ff) * 64'(ny_b_ff);
         sq_z_ff    <= 64'(nz_b_ff) * 64'(nz_b_ff);
         p_xy_ff    <= 64'(nx_b_ff) * 64'(ny_b_ff);
         p_xz_ff    <= 64'(nx_b_ff) * 64'(nz_b_ff);
         mag_y_ff   <= (ny_b_ff < 0) ? 32'(-ny_b_ff) : 32'(ny_b_ff);
         mag_z_ff   <= (nz_b_ff < 0) ? 32'(-nz_b_ff) : 32'(nz_b_ff);
         deg_c_ff   <= (ny_b_ff == 0);
         neg_z_c_ff <= (ny_b_ff >= 0) ? (nz_b_ff > 0) : (nz_b_ff < 0);
         n_ff       <= 64'(sq_y_ff) + 64'(sq_z_ff);
         ipay_ff    <= {flags_d,
                        (p_xy_ff < 0) ? 64'(-p_xy_ff) : 64'(p_xy_ff),
                        (p_xz_ff < 0) ? 64'(-p_xz_ff) : 64'(p_xz_ff),
                        64'(mag_z_ff) << 30,
                        64'(mag_y_ff) << 30};
      end
   end

   logic           sv;
   logic [31:0]    s_root;
   logic [IPW-1:0] s_pay;

   tpb_isqrt_pipe #(
      .RW (32),
      .PW (IPW)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vd_ff),
      .in_n      (n_ff),
      .in_pay    (ipay_ff),
      .out_valid (sv),
      .out_root  (s_root),
      .out_pay   (s_pay)
   );

   // rounded dividends
   tpb_pkg::tpb_flags_type flags_e_ff;
   logic        ve_ff;
   logic [31:0] s_e_ff;
   logic [64:0] d_xy_ff;
   logic [64:0] d_xz_ff;
   logic [64:0] d_z_ff;
   logic [64:0] d_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (en) begin
         ve_ff <= sv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flags_e_ff <= s_pay[IPW-1 -: FW];
         s_e_ff     <= s_root;
         d_xy_ff    <= 65'(s_pay[255:192]) + 65'(s_root >> 1);
         d_xz_ff    <= 65'(s_pay[191:128]) + 65'(s_root >> 1);
         d_z_ff     <= 65'(s_pay[127:64]) + 65'(s_root >> 1);
         d_y_ff     <= 65'(s_pay[63:0]) + 65'(s_root >> 1);
      end
   end

   logic        qv_xy;
   logic        qv_xz;
   logic        qv_z;
   logic        qv_y;
   logic [32:0] q_xy;
   logic [32:0] q_xz;
   logic [32:0] q_z;
   logic [32:0] q_y;
   logic        ng_xy;
   logic        ng_xz;
   logic        ng_z;
   logic [32:0] q_pay;

   tpb_div_pipe #(.DW (32), .QW (33), .PW (1)) u_div_xy (
      .clock (clock), .reset (reset), .en (en), .in_valid (ve_ff),
      .in_rem (d_xy_ff[64:33]), .in_low (d_xy_ff[32:0]), .in_den (s_e_ff),
      .in_pay (flags_e_ff.neg_xy),
      .out_valid (qv_xy), .out_quo (q_xy), .out_pay (ng_xy)
   );

   tpb_div_pipe #(.DW (32), .QW (33), .PW (1)) u_div_xz (
      .clock (clock), .reset (reset), .en (en), .in_valid (ve_ff),
      .in_rem (d_xz_ff[64:33]), .in_low (d_xz_ff[32:0]), .in_den (s_e_ff),
      .in_pay (flags_e_ff.neg_xz),
      .out_valid (qv_xz), .out_quo (q_xz), .out_pay (ng_xz)
   );

   tpb_div_pipe #(.DW (32), .QW (33), .PW (1)) u_div_z (
      .clock (clock), .reset (reset), .en (en), .in_valid (ve_ff),
      .in_rem (d_z_ff[64:33]), .in_low (d_z_ff[32:0]), .in_den (s_e_ff),
      .in_pay (flags_e_ff.neg_z),
      .out_valid (qv_z), .out_quo (q_z), .out_pay (ng_z)
   );

   tpb_div_pipe #(.DW (32), .QW (33), .PW (33)) u_div_y (
      .clock (clock), .reset (reset), .en (en), .in_valid (ve_ff),
      .in_rem (d_y_ff[64:33]), .in_low (d_y_ff[32:0]), .in_den (s_e_ff),
      .in_pay ({flags_e_ff.degenerate, s_e_ff}),
      .out_valid (qv_y), .out_quo (q_y), .out_pay (q_pay)
   );

   // output register
   logic signed [34:0] v_xy;
   logic signed [34:0] v_xz;
   logic signed [34:0] v_z;
   logic [95:0]        data_in;
   logic               rsp_tvalid_ff;
   logic [95:0]        rsp_tdata_ff;
   logic               rsp_tuser_ff;

   always_comb begin
      v_xy = ng_xy ? -$signed({2'b00, q_xy}) : $signed({2'b00, q_xy});
      v_xz = ng_xz ? -$signed({2'b00, q_xz}) : $signed({2'b00, q_xz});
      v_z  = ng_z ? -$signed({2'b00, q_z}) : $signed({2'b00, q_z});
      if (q_pay[32]) begin
         data_in = '0;
      end else begin
         data_in = {to_out($signed({2'b00, q_y})),
                    to_out(v_z),
                    16'h0000,
                    to_out(v_xz),
                    to_out(v_xy),
                    to_out($signed({3'b000, q_pay[31:0]}))};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= qv_y;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= data_in;
         rsp_tuser_ff <= q_pay[32];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `TPB_ASSERT_ALWAYS(a_sincos_aligned, clock, reset, tv == rv)
   `TPB_ASSERT_ALWAYS(a_div_aligned, clock, reset,
      (qv_xy == qv_y) && (qv_xz == qv_y) && (qv_z == qv_y))
   `TPB_ASSERT_IMPLIES(a_deg_zero, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tdata == 96'd0)
   `TPB_ASSERT_IMPLIES(a_first_x_pos, clock, reset, rsp_tvalid && !rsp_tuser,
      !rsp_tdata[15])

endmodule
